/* hdl/cfawm_pkg.sv */
// shared types and codes for the window max anchor transport block
package cfawm_pkg;

    localparam int QW = 16;

    typedef logic [QW-1:0] quant_t;

    // result status codes
    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_BAD_ANCHOR = 2'd1;
    localparam logic [1:0] STS_OUTSIDE    = 2'd2;
    localparam logic [1:0] STS_LOAD_ERR   = 2'd3;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    // request kinds
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // one stored pixel
    typedef struct packed {
        logic [1:0] chan;
        logic       valid;
        quant_t     p50;
        quant_t     p95;
    } entry_t;

    // tag of one window read, aligned with the read data
    typedef struct packed {
        logic vld;
        logic last;
        logic center;
    } beat_t;

endpackage

/* hdl/cfawm_store.sv */
// pixel store memory: one write port, one registered read port
module cfawm_store #(
    parameter int AW = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  cfawm_pkg::entry_t wdata,
    input  logic [AW-1:0]     raddr,
    output cfawm_pkg::entry_t rdata
);
    import cfawm_pkg::*;

    entry_t mem [2**AW];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/cfawm_scan.sv */
// window scan sequencer: steps through the clipped window one pixel a cycle
module cfawm_scan #(
    parameter int XB = 8,
    parameter int YB = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [7:0]       pos_x,
    input  logic [7:0]       pos_y,
    input  logic [2:0]       radius,
    input  logic [8:0]       img_w,
    input  logic [8:0]       img_h,
    output logic [XB+YB-1:0] raddr,
    output cfawm_pkg::beat_t beat
);
    import cfawm_pkg::*;

    logic [8:0] x0_reg, x1_reg, y1_reg;
    logic [8:0] cx_reg, cy_reg;
    logic [8:0] px_reg, py_reg;
    logic       active_reg;
    beat_t      beat_reg;

    logic [8:0] xw, yw, xr, yr, x0_s, y0_s, x1_s, y1_s;
    logic       at_end;

    always_comb begin
        xw   = {1'b0, pos_x};
        yw   = {1'b0, pos_y};
        xr   = xw + {6'd0, radius};
        yr   = yw + {6'd0, radius};
        x0_s = (xw > {6'd0, radius}) ? xw - {6'd0, radius} : 9'd0;
        y0_s = (yw > {6'd0, radius}) ? yw - {6'd0, radius} : 9'd0;
        x1_s = (xr < img_w) ? xr : img_w - 9'd1;
        y1_s = (yr < img_h) ? yr : img_h - 9'd1;
    end

    assign at_end = (cx_reg == x1_reg) && (cy_reg == y1_reg);
    assign raddr  = {YB'(cy_reg), XB'(cx_reg)};
    assign beat   = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            beat_reg   <= '0;
        end else begin
            beat_reg.vld    <= active_reg;
            beat_reg.last   <= active_reg && at_end;
            beat_reg.center <= (cx_reg == px_reg) && (cy_reg == py_reg);
            if (start) begin
                active_reg <= 1'b1;
            end else if (active_reg && at_end) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x0_reg <= x0_s;
            x1_reg <= x1_s;
            y1_reg <= y1_s;
            cx_reg <= x0_s;
            cy_reg <= y0_s;
            px_reg <= xw;
            py_reg <= yw;
        end else if (active_reg) begin
            if (cx_reg == x1_reg) begin
                cx_reg <= x0_reg;
                cy_reg <= cy_reg + 9'd1;
            end else begin
                cx_reg <= cx_reg + 9'd1;
            end
        end
    end

endmodule

/* hdl/cfawm_maxacc.sv */
// shared max unit: folds one window entry a cycle into its channel's maxima
module cfawm_maxacc (
    input  logic                   aclk,
    input  logic                   start,
    input  cfawm_pkg::beat_t       beat,
    input  cfawm_pkg::entry_t      entry,
    output logic [2:0]             found,
    output cfawm_pkg::quant_t [2:0] max50,
    output cfawm_pkg::quant_t [2:0] max95
);
    import cfawm_pkg::*;

    logic [2:0]   found_reg;
    quant_t [2:0] m50_reg, m95_reg;
    logic [1:0]   mine_reg;

    // one compare pair, steered to the entry's channel
    quant_t     cur50, cur95, new50, new95;
    logic [1:0] sel;
    logic       hit;

    always_comb begin
        sel   = entry.chan[0] ? CH_GREEN : (entry.chan[1] ? CH_BLUE : CH_RED);
        cur50 = m50_reg[sel];
        cur95 = m95_reg[sel];
        new50 = (entry.p50 > cur50) ? entry.p50 : cur50;
        new95 = (entry.p95 > cur95) ? entry.p95 : cur95;
        hit   = beat.vld && entry.valid && (entry.chan != CH_NONE);
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            found_reg <= '0;
            m50_reg   <= '0;
            m95_reg   <= '0;
            mine_reg  <= CH_NONE;
        end else begin
            if (hit) begin
                for (int c = 0; c < 3; c++) begin
                    if (entry.chan == 2'(c)) begin
                        found_reg[c] <= 1'b1;
                        m50_reg[c]   <= new50;
                        m95_reg[c]   <= new95;
                    end
                end
            end
            if (beat.vld && beat.center) begin
                mine_reg <= entry.chan;
            end
        end
    end

    // the queried pixel's own channel reports nothing
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            found[c] = found_reg[c] && (mine_reg != 2'(c));
            max50[c] = found[c] ? m50_reg[c] : '0;
            max95[c] = found[c] ? m95_reg[c] : '0;
        end
    end

endmodule

/* hdl/cfa_window_max_anchor_transport.sv */
// top level of the window max anchor transport block
// usage:
//   s_ channel carries load and query requests; s_tuser selects the kind
//   (0 load, 1 query), s_tdata the pixel coordinate and anchor interval.
//   m_ channel returns one result per request: m_tuser holds the status,
//   m_tdata the found flag and p50/p95 window maxima of each channel.
//   cfg_ channel writes image width, image height and window radius;
//   write it only while no request is in flight. cfg_ready is always high.
// request handling:
//   a load, or a query rejected by the sticky error or the frame check,
//   has its result registered and shown the next cycle.
//   an accepted query reads the clipped window one entry a cycle through a
//   single read port; each entry and its tag are registered together and
//   folded into the max unit, then the sequencer waits in its finish state
//   until the output register is free and loads the result there. no new
//   request is taken during the scan or before that result is loaded.
// reset: synchronous active-low aresetn clears the sticky load error, the
//   sequencer and the result valid; width/height reset to 256, radius to 1;
//   the pixel store is not cleared: load every pixel before querying.
// stall: the result sits in an output register until m_tready; s_tready
//   stays low while that register holds a result that cannot move on.
module cfa_window_max_anchor_transport #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[7:0], pos_y[15:8], measured_channel[17:16], anchor_valid[18],
    // anchor_p50[34:19], anchor_p95[50:35], zero fill[55:51]
    input  logic [55:0]  s_tdata,
    // func[0]
    input  logic         s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_red[0], p50_red[16:1], p95_red[32:17], found_green[33],
    // p50_green[49:34], p95_green[65:50], found_blue[66], p50_blue[82:67],
    // p95_blue[98:83], zero fill[103:99]
    output logic [103:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);
    import cfawm_pkg::*;

    localparam int XB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = XB + YB;

    // clamp limits as 9-bit / 3-bit register values
    localparam logic [8:0] W_CAP = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
    localparam logic [8:0] H_CAP = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);
    localparam logic [2:0] R_CAP = (MAX_RADIUS > 7) ? 3'd7 : 3'(MAX_RADIUS);
    localparam logic [8:0] W_RST = (W_CAP < 9'd256) ? W_CAP : 9'd256;
    localparam logic [8:0] H_RST = (H_CAP < 9'd256) ? H_CAP : 9'd256;
    localparam logic [2:0] R_RST = 3'd1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [8:0]   img_w_reg, img_h_reg;
    logic [2:0]   radius_reg;
    logic         load_err_reg;
    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    // request fields
    logic       func;
    logic [7:0] pos_x, pos_y;
    logic [1:0] meas_ch;
    logic       anc_valid;
    quant_t     anc_p50, anc_p95;

    assign func      = s_tuser;
    assign pos_x     = s_tdata[7:0];
    assign pos_y     = s_tdata[15:8];
    assign meas_ch   = s_tdata[17:16];
    assign anc_valid = s_tdata[18];
    assign anc_p50   = s_tdata[34:19];
    assign anc_p95   = s_tdata[50:35];

    logic out_free, accept, outside, bad_anchor, start_scan, store_we, imm_result;
    logic [1:0] imm_status;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign outside    = ({1'b0, pos_x} >= img_w_reg) || ({1'b0, pos_y} >= img_h_reg);
    assign bad_anchor = anc_valid && ((meas_ch == CH_NONE) || (anc_p95 < anc_p50));
    assign store_we   = accept && (func == FUNC_LOAD) && !outside && !bad_anchor;
    assign start_scan = accept && (func == FUNC_QUERY) && !load_err_reg && !outside;
    assign imm_result = accept && !start_scan;

    // status of a request answered without a scan; sticky error wins for queries
    always_comb begin
        if (func == FUNC_QUERY) begin
            imm_status = load_err_reg ? STS_LOAD_ERR : STS_OUTSIDE;
        end else if (outside) begin
            imm_status = STS_OUTSIDE;
        end else if (bad_anchor) begin
            imm_status = STS_BAD_ANCHOR;
        end else begin
            imm_status = STS_OK;
        end
    end

    // pixel store
    entry_t          wentry, rentry;
    logic [AW-1:0]   waddr, raddr;
    beat_t           beat;

    assign waddr        = {YB'(pos_y), XB'(pos_x)};
    assign wentry.chan  = meas_ch;
    assign wentry.valid = anc_valid;
    assign wentry.p50   = anc_valid ? anc_p50 : '0;
    assign wentry.p95   = anc_valid ? anc_p95 : '0;

    cfawm_store #(.AW(AW)) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rentry)
    );

    // window address sequencer
    cfawm_scan #(.XB(XB), .YB(YB)) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_scan),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .radius  (radius_reg),
        .img_w   (img_w_reg),
        .img_h   (img_h_reg),
        .raddr   (raddr),
        .beat    (beat)
    );

    // shared max unit
    logic [2:0]   found;
    quant_t [2:0] max50, max95;

    cfawm_maxacc u_maxacc (
        .aclk  (aclk),
        .start (start_scan),
        .beat  (beat),
        .entry (rentry),
        .found (found),
        .max50 (max50),
        .max95 (max95)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start_scan) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (beat.vld && beat.last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic fin_load;
    assign fin_load = (state_reg == S_FIN) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            load_err_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && (func == FUNC_LOAD) && !outside && bad_anchor) begin
                load_err_reg <= 1'b1;
            end
            if (imm_result || fin_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (imm_result) begin
            m_tuser_reg <= imm_status;
            m_tdata_reg <= '0;
        end else if (fin_load) begin
            m_tuser_reg <= STS_OK;
            m_tdata_reg <= {5'd0,
                            max95[2], max50[2], found[2],
                            max95[1], max50[1], found[1],
                            max95[0], max50[0], found[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // configuration registers, clamped on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg  <= W_RST;
            img_h_reg  <= H_RST;
            radius_reg <= R_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH: begin
                    img_w_reg <= (cfg_data < 9'd2) ? 9'd2 :
                                 ((cfg_data > W_CAP) ? W_CAP : cfg_data);
                end
                REG_HEIGHT: begin
                    img_h_reg <= (cfg_data < 9'd2) ? 9'd2 :
                                 ((cfg_data > H_CAP) ? H_CAP : cfg_data);
                end
                REG_RADIUS: begin
                    radius_reg <= (cfg_data[2:0] < 3'd1) ? 3'd1 :
                                  ((cfg_data[2:0] > R_CAP) ? R_CAP : cfg_data[2:0]);
                end
                default: ;
            endcase
        end
    end

endmodule

/* sim/tb_cfa_window_max_anchor_transport.sv */
`timescale 1ns / 1ps
// testbench for the window max anchor transport block: loads, window queries, sticky error
module tb_cfa_window_max_anchor_transport;
    import cfawm_pkg::*;

    localparam int         FRAME_MAX    = 256;
    localparam int         RADIUS_MAX   = 7;
    localparam int         ITEM_TARGET  = 1500;
    // longest correct run of cycles with no handshake is a full scan plus long stalls
    // on both sides, or the final drain; this leaves a wide margin over both
    localparam int         STALL_LIMIT  = 5000;
    // outlasts a full radius-7 scan, so this catches any late stray result
    localparam int         DRAIN_CYCLES = 240;
    localparam int         MAX_REPORTS  = 10;
    // index with no register behind it
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    // one request as the block sees it
    typedef struct packed {
        logic       func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [1:0] chan;
        logic       anchor_valid;
        quant_t     p50;
        quant_t     p95;
    } request_t;

    // one channel of a result, laid out as in m_tdata (found flag lowest)
    typedef struct packed {
        quant_t p95;
        quant_t p50;
        logic   found;
    } chan_max_t;

    typedef struct packed {
        logic [1:0]      status;
        chan_max_t [2:0] chans;
    } result_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [8:0]   cfg_data  = '0;

    cfa_window_max_anchor_transport dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow of the block: pixel store, sticky flag and the clamped registers
    logic [1:0]  pix_chan   [FRAME_MAX*FRAME_MAX];
    logic        pix_anchor [FRAME_MAX*FRAME_MAX];
    quant_t      pix_p50    [FRAME_MAX*FRAME_MAX];
    quant_t      pix_p95    [FRAME_MAX*FRAME_MAX];
    // pixels stored at least once; a query window only ever covers these
    bit          pix_loaded [FRAME_MAX*FRAME_MAX];
    bit          sticky_err = 1'b0;
    int unsigned frame_w    = FRAME_MAX;
    int unsigned frame_h    = FRAME_MAX;
    int unsigned win_r      = 1;

    result_t     expected_results [$];
    int          mismatches   = 0;
    int          sent_items   = 0;
    int          quiet_cycles = 0;
    int unsigned ready_hold   = 0;
    // set for whole phases that run with no gaps on either side
    bit          no_idle      = 1'b0;
    string       chan_name [3] = '{"red", "green", "blue"};

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // quantile with extra weight on both ends of the range
    function automatic quant_t rand_quant();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return quant_t'($urandom());
    endfunction

    function automatic request_t rand_request();
        request_t req;
        req.func         = 1'($urandom());
        req.pos_x        = 8'($urandom());
        req.pos_y        = 8'($urandom());
        req.chan         = 2'($urandom());
        req.anchor_valid = 1'($urandom());
        req.p50          = rand_quant();
        req.p95          = rand_quant();
        return req;
    endfunction

    function automatic request_t load_req(input logic [7:0] x, input logic [7:0] y,
                                          input logic [1:0] ch, input logic av,
                                          input quant_t p50, input quant_t p95);
        request_t req;
        req.func         = FUNC_LOAD;
        req.pos_x        = x;
        req.pos_y        = y;
        req.chan         = ch;
        req.anchor_valid = av;
        req.p50          = p50;
        req.p95          = p95;
        return req;
    endfunction

    // a load that is always stored: ordered anchor on a real channel, or no anchor
    function automatic request_t make_load(input logic [7:0] x, input logic [7:0] y);
        request_t req;
        quant_t   a, b;
        req       = rand_request();
        req.func  = FUNC_LOAD;
        req.pos_x = x;
        req.pos_y = y;
        if ($urandom_range(0, 9) < 7) begin
            req.anchor_valid = 1'b1;
            req.chan         = 2'($urandom_range(0, 2));
            a                = rand_quant();
            b                = rand_quant();
            req.p50          = (a < b) ? a : b;
            req.p95          = (a < b) ? b : a;
        end else begin
            // no anchor: channel may be the none code, quantiles are don't care
            req.anchor_valid = 1'b0;
        end
        return req;
    endfunction

    // expected answer to one request; updates the shadow state like the block does
    function automatic result_t predict_result(input request_t req);
        result_t     res;
        int unsigned idx, own, x0, x1, y0, y1, xx, yy, c;
        bit          any;
        quant_t      m50, m95;
        res = '0;
        res.status = STS_OK;
        idx = int'(req.pos_y) * FRAME_MAX + int'(req.pos_x);
        if (req.func == FUNC_LOAD) begin
            if (req.pos_x >= frame_w || req.pos_y >= frame_h) begin
                res.status = STS_OUTSIDE;
            end else if (req.anchor_valid && (req.chan == CH_NONE || req.p95 < req.p50)) begin
                sticky_err = 1'b1;
                res.status = STS_BAD_ANCHOR;
            end else begin
                pix_chan[idx]   = req.chan;
                pix_anchor[idx] = req.anchor_valid;
                pix_p50[idx]    = req.anchor_valid ? req.p50 : '0;
                pix_p95[idx]    = req.anchor_valid ? req.p95 : '0;
                pix_loaded[idx] = 1'b1;
            end
        end else if (sticky_err) begin
            // sticky error wins over the frame check
            res.status = STS_LOAD_ERR;
        end else if (req.pos_x >= frame_w || req.pos_y >= frame_h) begin
            res.status = STS_OUTSIDE;
        end else begin
            own = pix_chan[idx];
            x0  = (req.pos_x > win_r) ? req.pos_x - win_r : 0;
            y0  = (req.pos_y > win_r) ? req.pos_y - win_r : 0;
            x1  = (req.pos_x + win_r < frame_w) ? req.pos_x + win_r : frame_w - 1;
            y1  = (req.pos_y + win_r < frame_h) ? req.pos_y + win_r : frame_h - 1;
            for (c = 0; c < 3; c++) begin
                if (c == own) continue;
                any = 1'b0;
                m50 = '0;
                m95 = '0;
                for (yy = y0; yy <= y1; yy++) begin
                    for (xx = x0; xx <= x1; xx++) begin
                        idx = yy * FRAME_MAX + xx;
                        if (pix_chan[idx] == c && pix_anchor[idx]) begin
                            if (pix_p50[idx] > m50) m50 = pix_p50[idx];
                            if (pix_p95[idx] > m95) m95 = pix_p95[idx];
                            any = 1'b1;
                        end
                    end
                end
                if (any) begin
                    res.chans[c].found = 1'b1;
                    res.chans[c].p50   = m50;
                    res.chans[c].p95   = m95;
                end
            end
        end
        return res;
    endfunction

    // drive one request and hold it until taken; valid stays high when no gap follows
    task automatic send_request(input request_t req);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req.func;
        s_tdata  <= {5'b0, req.p95, req.p50, req.anchor_valid, req.chan,
                     req.pos_y, req.pos_x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_result(req));
        sent_items++;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // query one pixel; before a scan, loads the part of its window never stored
    task automatic query_pixel(input logic [7:0] x, input logic [7:0] y);
        int unsigned x0, x1, y0, y1, xx, yy;
        request_t    req;
        if (!sticky_err && x < frame_w && y < frame_h) begin
            x0 = (x > win_r) ? x - win_r : 0;
            y0 = (y > win_r) ? y - win_r : 0;
            x1 = (x + win_r < frame_w) ? x + win_r : frame_w - 1;
            y1 = (y + win_r < frame_h) ? y + win_r : frame_h - 1;
            for (yy = y0; yy <= y1; yy++) begin
                for (xx = x0; xx <= x1; xx++) begin
                    if (!pix_loaded[yy * FRAME_MAX + xx]) begin
                        send_request(make_load(8'(xx), 8'(yy)));
                    end
                end
            end
        end
        // the ignored fields of a query carry random junk
        req       = rand_request();
        req.func  = FUNC_QUERY;
        req.pos_x = x;
        req.pos_y = y;
        send_request(req);
    endtask

    // stop requesting and wait until every pending result came back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // one register request; valid is only lowered after the last of a burst
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_WIDTH:  frame_w = clamp_reg(val, 2, FRAME_MAX);
            REG_HEIGHT: frame_h = clamp_reg(val, 2, FRAME_MAX);
            REG_RADIUS: win_r   = clamp_reg(val[2:0], 1, RADIUS_MAX);
            default: ;
        endcase
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [8:0] w, input logic [8:0] h, input logic [8:0] r);
        wait_idle();
        write_reg(REG_WIDTH, w, 1'b0);
        write_reg(REG_HEIGHT, h, 1'b0);
        write_reg(REG_RADIUS, r, 1'b1);
    endtask

    // hand-picked contents on a tiny frame: quantile extremes, the none channel,
    // equal quantiles, edge clipping, frame checks and an unknown register
    task automatic test_small_frame();
        // height and radius are written below range and clamp to 2 and 1
        set_frame(9'd3, 9'd1, 9'd0);
        send_request(load_req(8'd0, 8'd0, CH_RED,   1'b1, 16'h0000, 16'hFFFF));
        send_request(load_req(8'd1, 8'd0, CH_GREEN, 1'b1, 16'hFFFF, 16'hFFFF));
        send_request(load_req(8'd2, 8'd0, CH_BLUE,  1'b1, 16'h1234, 16'h1234));
        // no anchor: inverted junk quantiles must not count as an error
        send_request(load_req(8'd0, 8'd1, CH_NONE,  1'b0, 16'hFFFF, 16'h0000));
        send_request(load_req(8'd1, 8'd1, CH_GREEN, 1'b1, 16'h0100, 16'h0200));
        send_request(load_req(8'd2, 8'd1, CH_RED,   1'b1, 16'h0005, 16'h0006));
        query_pixel(8'd0, 8'd0);
        query_pixel(8'd1, 8'd1);
        query_pixel(8'd2, 8'd1);
        query_pixel(8'd1, 8'd0);
        query_pixel(8'd0, 8'd1);
        // outside the frame: even an inverted anchor only answers the frame check
        send_request(load_req(8'd3, 8'd0, CH_GREEN, 1'b1, 16'h0100, 16'h0050));
        query_pixel(8'd0, 8'd2);
        send_request(load_req(8'd255, 8'd255, CH_BLUE, 1'b1, 16'h0001, 16'h0002));
        wait_idle();
        write_reg(REG_RADIUS, 9'd7, 1'b0);
        write_reg(REG_UNUSED, 9'h1FF, 1'b1);
        query_pixel(8'd0, 8'd1);
        query_pixel(8'd2, 8'd0);
    endtask

    // widest, tallest and clamped frames with queries at the corners and along the edges
    task automatic test_frame_extremes();
        set_frame(9'd256, 9'd2, 9'd7);
        query_pixel(8'd255, 8'd1);
        query_pixel(8'd0, 8'd0);
        query_pixel(8'd128, 8'd0);
        query_pixel(8'd200, 8'd1);
        set_frame(9'd2, 9'd256, 9'd7);
        query_pixel(8'd1, 8'd255);
        query_pixel(8'd0, 8'd128);
        query_pixel(8'd0, 8'd0);
        // above range: both clamp to the full frame
        set_frame(9'h1FF, 9'd300, 9'd7);
        query_pixel(8'd255, 8'd255);
        query_pixel(8'd255, 8'd0);
        // below range: clamps to a 2 by 2 frame
        set_frame(9'd0, 9'd0, 9'd1);
        query_pixel(8'd1, 8'd1);
        query_pixel(8'd0, 8'd0);
        send_request(load_req(8'd2, 8'd0, CH_RED, 1'b0, 16'h0000, 16'h0000));
        query_pixel(8'd0, 8'd5);
    endtask

    // phases of random frames and radii; mostly queries over loaded windows
    task automatic test_random_traffic();
        int unsigned phase_items, kind, k;
        logic [8:0]  w_raw, h_raw, r_raw;
        logic [7:0]  x, y;
        request_t    req;
        while (sent_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    w_raw = 9'($urandom_range(256, 511));
                    h_raw = 9'($urandom_range(2, 6));
                end
                1: begin
                    w_raw = 9'($urandom_range(2, 6));
                    h_raw = 9'($urandom_range(256, 511));
                end
                2: begin
                    w_raw = 9'($urandom_range(0, 511));
                    h_raw = 9'($urandom_range(0, 20));
                end
                default: begin
                    w_raw = 9'($urandom_range(2, 16));
                    h_raw = 9'($urandom_range(2, 16));
                end
            endcase
            // occasionally junk in the upper data bits of the radius write
            r_raw = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                : 9'($urandom_range(0, RADIUS_MAX));
            set_frame(w_raw, h_raw, r_raw);
            no_idle     = ($urandom_range(0, 4) == 0);
            phase_items = $urandom_range(40, 150);
            for (k = 0; k < phase_items && sent_items < ITEM_TARGET; k++) begin
                kind = $urandom_range(0, 99);
                x    = 8'($urandom_range(0, frame_w - 1));
                y    = 8'($urandom_range(0, frame_h - 1));
                if (kind < 55) begin
                    query_pixel(x, y);
                end else if (kind < 90) begin
                    send_request(make_load(x, y));
                end else begin
                    // outside the frame with fully random content, either kind
                    req = rand_request();
                    if (frame_w < FRAME_MAX) begin
                        req.pos_x = 8'($urandom_range(frame_w, FRAME_MAX - 1));
                    end else begin
                        req.pos_y = 8'($urandom_range(frame_h, FRAME_MAX - 1));
                    end
                    send_request(req);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // bad loads set the sticky error; from then on every query answers it.
    // runs last since only reset clears the flag
    task automatic test_sticky_error();
        int unsigned k;
        set_frame(9'd8, 9'd8, 9'd2);
        query_pixel(8'd3, 8'd3);
        // anchor on the none channel is rejected even with ordered quantiles
        send_request(load_req(8'd1, 8'd1, CH_NONE, 1'b1, 16'h0010, 16'h0020));
        send_request(load_req(8'd2, 8'd2, CH_BLUE, 1'b1, 16'hFFFF, 16'hFFFE));
        query_pixel(8'd3, 8'd3);
        // sticky error is checked before the frame
        query_pixel(8'd20, 8'd20);
        // loads keep working
        send_request(load_req(8'd4, 8'd4, CH_GREEN, 1'b1, 16'h0030, 16'h0040));
        send_request(load_req(8'd9, 8'd0, CH_RED, 1'b0, 16'h0000, 16'h0000));
        for (k = 0; k < 30; k++) begin
            send_request(rand_request());
        end
    endtask

    task automatic flag_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // every accepted result against the oldest pending expectation
    always @(posedge aclk) begin : check_results
        result_t   want;
        chan_max_t got;
        int        c;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("status of a result with no request pending", 0, m_tuser);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status) flag_mismatch("status", want.status, m_tuser);
                if (m_tdata[103:99] !== '0) flag_mismatch("zero fill", 0, m_tdata[103:99]);
                for (c = 0; c < 3; c++) begin
                    got = m_tdata[c*33 +: 33];
                    if (got.found !== want.chans[c].found) begin
                        flag_mismatch({"found_", chan_name[c]}, want.chans[c].found, got.found);
                    end
                    if (got.p50 !== want.chans[c].p50) begin
                        flag_mismatch({"p50_", chan_name[c]}, want.chans[c].p50, got.p50);
                    end
                    if (got.p95 !== want.chans[c].p95) begin
                        flag_mismatch({"p95_", chan_name[c]}, want.chans[c].p95, got.p95);
                    end
                end
            end
        end
    end

    // receiver back-pressure: random stalls of random length
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    // ends a run that stops moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_small_frame();
        test_frame_extremes();
        test_random_traffic();
        test_sticky_error();
        wait_idle();
        // a stray result after the last expected one still gets caught
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
